FILE: src/mtq_pkg.sv
// shared types, codes and default sizes for the multi-event timer queue
// no dependencies; used by mtq_cmp_unit, the top level and the testbench by scoped names
`default_nettype none

package mtq_pkg;

   // default sizes, handed to the top level parameters as their defaults
   localparam int SLOTS_DEF      = 16;
   localparam int ID_BITS_DEF    = 8;
   localparam int TIME_BITS_DEF  = 32;
   localparam int DELAY_BITS_DEF = 16;

   // most expired events reported by one tick request
   localparam int MAX_OUT = 16;

   // request operation codes
   localparam logic [1:0] MODE_ADD    = 2'd0;
   localparam logic [1:0] MODE_REMOVE = 2'd1;
   localparam logic [1:0] MODE_TICK   = 2'd2;
   localparam logic [1:0] MODE_QUERY  = 2'd3;

   // result status codes
   localparam logic [2:0] ST_DONE      = 3'd0;
   localparam logic [2:0] ST_EXPIRED   = 3'd1;
   localparam logic [2:0] ST_NONE_DUE  = 3'd2;
   localparam logic [2:0] ST_DUPLICATE = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_FULL      = 3'd5;

   // flags from the shared slot compare unit
   typedef struct packed {
      logic id_hit;   // slot holds the requested identifier
      logic rem_le;   // slot remaining time is at most the new delay
      logic due;      // slot expires at the current tick
   } cmp_flags_type;

endpackage

`default_nettype wire

FILE: src/mtq_slot_ram.sv
// slot table memory: one write port, one read port with registered data
// depends on nothing; sized by the top level
`default_nettype none

module mtq_slot_ram #(
   parameter int SLOTS = 16,
   parameter int WIDTH = 40
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(SLOTS)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire [$clog2(SLOTS)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);

   logic [WIDTH-1:0] mem [SLOTS];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: src/mtq_cmp_unit.sv
// shared compare unit: checks one slot against the latched request
// depends on mtq_pkg for the flag struct
`default_nettype none

module mtq_cmp_unit #(
   parameter int ID_BITS   = 8,
   parameter int TIME_BITS = 32
) (
   input  wire [TIME_BITS-1:0]     slot_expiry,
   input  wire [ID_BITS-1:0]       slot_event,
   input  wire [ID_BITS-1:0]       key_id,
   input  wire [TIME_BITS-1:0]     key_delay,
   input  wire [TIME_BITS-1:0]     now_ticks,
   output mtq_pkg::cmp_flags_type  flags
);

   logic [TIME_BITS-1:0] remain;

   // remaining time wraps with the counter
   assign remain = slot_expiry - now_ticks;

   always_comb begin
      flags.id_hit = (slot_event == key_id);
      flags.rem_le = (remain <= key_delay);
      flags.due    = (slot_expiry == now_ticks);
   end

endmodule

`default_nettype wire

FILE: src/multi_event_timer_queue.sv
// top level of the multi-event timer queue: sequencer, time counter, result register
// depends on mtq_pkg, mtq_slot_ram and mtq_cmp_unit
`default_nettype none

// Sorted queue of up to SLOTS armed timer events, kept in order of expiry and arrival in
// a slot memory with one write port and one registered read port. A request is taken
// when start is high and busy is low; busy stays high until the request is finished.
// Every slot read goes through the registered read port and one shared compare unit.
// Add, remove and query scan all occupied slots and then decide; query and every error
// end there, while add and remove move the slots behind the change and then close. A
// tick reads the head, checks slots from the head until the first one not due, the
// sixteenth due one or the end of the table, reports the due events, moves the rest of
// the table up and closes; if the head is not due it answers none due instead. A tick
// on an empty table keeps busy low and answers in the next cycle. Results appear on the
// rsp_ ports for exactly one cycle each, marked by rsp_strobe; the receiver cannot stall
// them, and rsp_last flags the final result of a request.

module multi_event_timer_queue #(
   parameter int SLOTS      = mtq_pkg::SLOTS_DEF,
   parameter int ID_BITS    = mtq_pkg::ID_BITS_DEF,
   parameter int TIME_BITS  = mtq_pkg::TIME_BITS_DEF,
   parameter int DELAY_BITS = mtq_pkg::DELAY_BITS_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  wire [1:0]               req_mode,
   input  wire [ID_BITS-1:0]       req_event_id,
   input  wire [DELAY_BITS-1:0]    req_delay,
   output logic                    rsp_strobe,
   output logic [2:0]              rsp_status,
   output logic [ID_BITS-1:0]      rsp_event_id_res,
   output logic                    rsp_pending,
   output logic                    rsp_any_pending,
   output logic                    rsp_last
);

   localparam int AW    = $clog2(SLOTS);
   localparam int CW    = $clog2(SLOTS + 1);
   localparam int DW    = TIME_BITS + ID_BITS;
   localparam int WIDE  = (DELAY_BITS > TIME_BITS) ? DELAY_BITS : TIME_BITS;

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SC_RD  = 4'd1;
   localparam logic [3:0] S_SC_EV  = 4'd2;
   localparam logic [3:0] S_DECIDE = 4'd3;
   localparam logic [3:0] S_MV_RD  = 4'd4;
   localparam logic [3:0] S_MV_WR  = 4'd5;
   localparam logic [3:0] S_INS    = 4'd6;
   localparam logic [3:0] S_DONE   = 4'd7;
   localparam logic [3:0] S_TK_RD0 = 4'd8;
   localparam logic [3:0] S_TK_EV0 = 4'd9;
   localparam logic [3:0] S_TD_RD  = 4'd10;
   localparam logic [3:0] S_TD_EV  = 4'd11;
   localparam logic [3:0] S_EM_RD  = 4'd12;
   localparam logic [3:0] S_EM_EV  = 4'd13;

   logic [3:0]            state_ff, state_in;
   logic [1:0]            mode_ff, mode_in;
   logic [ID_BITS-1:0]    id_ff, id_in;
   logic [TIME_BITS-1:0]  delay_ff, delay_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [TIME_BITS-1:0]  now_ff, now_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic [CW-1:0]         hit_ff, hit_in;
   logic [CW-1:0]         pos_ff, pos_in;
   logic [CW-1:0]         off_ff, off_in;
   logic                  found_ff, found_in;
   logic                  pos_set_ff, pos_set_in;

   logic                  rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]            rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    rsp_id_ff, rsp_id_in;
   logic                  rsp_pending_ff, rsp_pending_in;
   logic                  rsp_any_ff, rsp_any_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic [WIDE-1:0]       delay_wide;
   logic [TIME_BITS-1:0]  delay_clamp;
   logic [CW:0]           nxt_idx;
   logic [CW:0]           src_up;
   logic [CW:0]           count_wide;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DW-1:0]         wr_data;
   logic [AW-1:0]         rd_addr;
   logic [DW-1:0]         rd_data;
   logic [TIME_BITS-1:0]  rd_expiry;
   logic [ID_BITS-1:0]    rd_event;

   mtq_pkg::cmp_flags_type flags;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // delay clamp: zero becomes one, too long saturates to the counter range
   assign delay_wide = WIDE'(req_delay);
   always_comb begin
      if (req_delay == '0) begin
         delay_clamp = TIME_BITS'(1);
      end else if (delay_wide > WIDE'({TIME_BITS{1'b1}})) begin
         delay_clamp = {TIME_BITS{1'b1}};
      end else begin
         delay_clamp = TIME_BITS'(delay_wide);
      end
   end

   assign nxt_idx    = (CW+1)'(idx_ff) + (CW+1)'(1);
   assign src_up     = (CW+1)'(idx_ff) + (CW+1)'(off_ff);
   assign count_wide = (CW+1)'(count_ff);

   assign rd_expiry = rd_data[DW-1:ID_BITS];
   assign rd_event  = rd_data[ID_BITS-1:0];

   // slot storage
   mtq_slot_ram #(
      .SLOTS (SLOTS),
      .WIDTH (DW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // shared slot compare
   mtq_cmp_unit #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_cmp (
      .slot_expiry (rd_expiry),
      .slot_event  (rd_event),
      .key_id      (id_ff),
      .key_delay   (delay_ff),
      .now_ticks   (now_ff),
      .flags       (flags)
   );

   // sequencer
   always_comb begin
      state_in       = state_ff;
      mode_in        = mode_ff;
      id_in          = id_ff;
      delay_in       = delay_ff;
      count_in       = count_ff;
      now_in         = now_ff;
      idx_in         = idx_ff;
      hit_in         = hit_ff;
      pos_in         = pos_ff;
      off_in         = off_ff;
      found_in       = found_ff;
      pos_set_in     = pos_set_ff;
      rsp_strobe_in  = 1'b0;
      rsp_status_in  = rsp_status_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_pending_in = rsp_pending_ff;
      rsp_any_in     = rsp_any_ff;
      rsp_last_in    = rsp_last_ff;
      wr_en          = 1'b0;
      wr_addr        = idx_ff[AW-1:0];
      wr_data        = rd_data;
      rd_addr        = idx_ff[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in    = req_mode;
               id_in      = req_event_id;
               delay_in   = delay_clamp;
               idx_in     = '0;
               hit_in     = '0;
               pos_in     = count_ff;
               off_in     = '0;
               found_in   = 1'b0;
               pos_set_in = 1'b0;
               if (req_mode == mtq_pkg::MODE_TICK) begin
                  if (count_ff == '0) begin
                     // empty table: advance and report nothing due
                     now_in         = now_ff + TIME_BITS'(1);
                     rsp_strobe_in  = 1'b1;
                     rsp_status_in  = mtq_pkg::ST_NONE_DUE;
                     rsp_id_in      = '0;
                     rsp_pending_in = 1'b0;
                     rsp_any_in     = 1'b0;
                     rsp_last_in    = 1'b1;
                  end else begin
                     state_in = S_TK_RD0;
                  end
               end else if (count_ff == '0) begin
                  state_in = S_DECIDE;
               end else begin
                  state_in = S_SC_RD;
               end
            end
         end

         // scan every occupied slot for the identifier and the insert point
         S_SC_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_SC_EV;
         end
         S_SC_EV: begin
            if (flags.id_hit && !found_ff) begin
               found_in = 1'b1;
               hit_in   = idx_ff;
            end
            if (!flags.rem_le && !pos_set_ff) begin
               pos_set_in = 1'b1;
               pos_in     = idx_ff;
            end
            idx_in = nxt_idx[CW-1:0];
            if (nxt_idx == count_wide) begin
               state_in = S_DECIDE;
            end else begin
               state_in = S_SC_RD;
            end
         end

         S_DECIDE: begin
            rsp_id_in   = id_ff;
            rsp_any_in  = (count_ff != '0);
            rsp_last_in = 1'b1;
            unique case (mode_ff)
               mtq_pkg::MODE_QUERY: begin
                  rsp_strobe_in  = 1'b1;
                  rsp_status_in  = mtq_pkg::ST_DONE;
                  rsp_pending_in = found_ff;
                  state_in       = S_IDLE;
               end
               mtq_pkg::MODE_REMOVE: begin
                  if (!found_ff) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_status_in  = mtq_pkg::ST_NOT_FOUND;
                     rsp_pending_in = 1'b0;
                     state_in       = S_IDLE;
                  end else begin
                     idx_in   = hit_ff;
                     off_in   = CW'(1);
                     state_in = S_MV_RD;
                  end
               end
               mtq_pkg::MODE_ADD: begin
                  if (found_ff) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_status_in  = mtq_pkg::ST_DUPLICATE;
                     rsp_pending_in = 1'b1;
                     state_in       = S_IDLE;
                  end else if (count_wide == (CW+1)'(SLOTS)) begin
                     rsp_strobe_in  = 1'b1;
                     rsp_status_in  = mtq_pkg::ST_FULL;
                     rsp_pending_in = 1'b0;
                     state_in       = S_IDLE;
                  end else begin
                     idx_in   = count_ff;
                     state_in = S_MV_RD;
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         // move slots: down by one for add, up by the offset otherwise
         S_MV_RD: begin
            if (mode_ff == mtq_pkg::MODE_ADD) begin
               if (idx_ff == pos_ff) begin
                  state_in = S_INS;
               end else begin
                  rd_addr  = AW'(idx_ff - CW'(1));
                  state_in = S_MV_WR;
               end
            end else begin
               if (src_up >= count_wide) begin
                  state_in = S_DONE;
               end else begin
                  rd_addr  = src_up[AW-1:0];
                  state_in = S_MV_WR;
               end
            end
         end
         S_MV_WR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            if (mode_ff == mtq_pkg::MODE_ADD) begin
               idx_in = idx_ff - CW'(1);
            end else begin
               idx_in = nxt_idx[CW-1:0];
            end
            state_in = S_MV_RD;
         end

         // write the new event into its gap
         S_INS: begin
            wr_en          = 1'b1;
            wr_addr        = pos_ff[AW-1:0];
            wr_data        = {now_ff + delay_ff, id_ff};
            count_in       = count_ff + CW'(1);
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = mtq_pkg::ST_DONE;
            rsp_id_in      = id_ff;
            rsp_pending_in = 1'b1;
            rsp_any_in     = 1'b1;
            rsp_last_in    = 1'b1;
            state_in       = S_IDLE;
         end

         // close remove and tick: shrink the table
         S_DONE: begin
            count_in = count_ff - off_ff;
            if (mode_ff == mtq_pkg::MODE_REMOVE) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = mtq_pkg::ST_DONE;
               rsp_id_in      = id_ff;
               rsp_pending_in = 1'b0;
               rsp_any_in     = (count_ff != off_ff);
               rsp_last_in    = 1'b1;
            end
            state_in = S_IDLE;
         end

         // tick: hold the counter while the head is still due
         S_TK_RD0: begin
            rd_addr  = '0;
            state_in = S_TK_EV0;
         end
         S_TK_EV0: begin
            if (!flags.due) begin
               now_in = now_ff + TIME_BITS'(1);
            end
            idx_in   = '0;
            state_in = S_TD_RD;
         end

         // count due events at the head
         S_TD_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_TD_EV;
         end
         S_TD_EV: begin
            if (flags.due) begin
               off_in = nxt_idx[CW-1:0];
               if (nxt_idx == count_wide || 32'(nxt_idx) == 32'(mtq_pkg::MAX_OUT)) begin
                  idx_in   = '0;
                  state_in = S_EM_RD;
               end else begin
                  idx_in   = nxt_idx[CW-1:0];
                  state_in = S_TD_RD;
               end
            end else if (idx_ff == '0) begin
               rsp_strobe_in  = 1'b1;
               rsp_status_in  = mtq_pkg::ST_NONE_DUE;
               rsp_id_in      = '0;
               rsp_pending_in = 1'b0;
               rsp_any_in     = 1'b1;
               rsp_last_in    = 1'b1;
               state_in       = S_IDLE;
            end else begin
               idx_in   = '0;
               state_in = S_EM_RD;
            end
         end

         // report the due events in queue order
         S_EM_RD: begin
            rd_addr  = idx_ff[AW-1:0];
            state_in = S_EM_EV;
         end
         S_EM_EV: begin
            rsp_strobe_in  = 1'b1;
            rsp_status_in  = mtq_pkg::ST_EXPIRED;
            rsp_id_in      = rd_event;
            rsp_pending_in = 1'b0;
            rsp_any_in     = (count_ff != off_ff);
            rsp_last_in    = (nxt_idx == (CW+1)'(off_ff));
            if (nxt_idx == (CW+1)'(off_ff)) begin
               idx_in   = '0;
               state_in = S_MV_RD;
            end else begin
               idx_in   = nxt_idx[CW-1:0];
               state_in = S_EM_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         now_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         now_ff        <= now_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // request and scan payload registers
   always_ff @(posedge clock) begin
      mode_ff        <= mode_in;
      id_ff          <= id_in;
      delay_ff       <= delay_in;
      idx_ff         <= idx_in;
      hit_ff         <= hit_in;
      pos_ff         <= pos_in;
      off_ff         <= off_in;
      found_ff       <= found_in;
      pos_set_ff     <= pos_set_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_pending_ff <= rsp_pending_in;
      rsp_any_ff     <= rsp_any_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_event_id_res = rsp_id_ff;
   assign rsp_pending      = rsp_pending_ff;
   assign rsp_any_pending  = rsp_any_ff;
   assign rsp_last         = rsp_last_ff;

   // table never holds more than its slots
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (CW+1)'(count_ff) <= (CW+1)'(SLOTS))
      else $error("slot count beyond table size");

   // more results still to come keep the block busy
   a_burst_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("non-final result while idle");

   // an expired event is no longer pending and the table shrinks afterwards
   a_expired: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == mtq_pkg::ST_EXPIRED) |-> (!rsp_pending && count_ff != '0))
      else $error("expired result with pending set or empty table");

endmodule

`default_nettype wire

FILE: tb/tb_multi_event_timer_queue.sv
// self-checking testbench for the multi-event timer queue: directed and random requests
// depends on mtq_pkg and multi_event_timer_queue; predicts every result in a local model
`timescale 1ns / 100ps

module tb_multi_event_timer_queue;

   localparam int SLOT_COUNT   = mtq_pkg::SLOTS_DEF;
   localparam int ID_W         = mtq_pkg::ID_BITS_DEF;
   localparam int TIME_W       = mtq_pkg::TIME_BITS_DEF;
   localparam int DELAY_W      = mtq_pkg::DELAY_BITS_DEF;
   localparam int RANDOM_ITEMS = 135;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 300;

   typedef struct packed {
      logic [1:0]         mode;
      logic [ID_W-1:0]    event_id;
      logic [DELAY_W-1:0] delay;
   } timer_request_type;

   typedef struct packed {
      logic [2:0]      status;
      logic [ID_W-1:0] event_id;
      logic            pending;
      logic            any_pending;
      logic            is_last;
   } timer_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_mode = '0;
   logic [ID_W-1:0]    req_event_id = '0;
   logic [DELAY_W-1:0] req_delay = '0;
   wire                busy;
   wire                rsp_strobe;
   wire [2:0]          rsp_status;
   wire [ID_W-1:0]     rsp_event_id_res;
   wire                rsp_pending;
   wire                rsp_any_pending;
   wire                rsp_last;

   // requests waiting to be driven and results waiting to arrive
   timer_request_type queued_requests[$];
   timer_result_type  due_results[$];
   int             total_requests = 0;
   int             issued_count = 0;
   int             taken_count = 0;
   int             error_count = 0;
   int             cycle_count = 0;

   // local copy of the timer table
   logic [TIME_W-1:0] model_expiry[SLOT_COUNT];
   logic [ID_W-1:0]   model_event[SLOT_COUNT];
   int                model_count = 0;
   logic [TIME_W-1:0] model_now = '0;

   multi_event_timer_queue u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_event_id     (req_event_id),
      .req_delay        (req_delay),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_event_id_res (rsp_event_id_res),
      .rsp_pending      (rsp_pending),
      .rsp_any_pending  (rsp_any_pending),
      .rsp_last         (rsp_last)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
      error_count++;
   endtask

   task automatic queue_request(input logic [1:0] mode, input int id, input int delay);
      queued_requests.push_back('{mode, id[ID_W-1:0], delay[DELAY_W-1:0]});
      total_requests++;
   endtask

   function automatic int find_event(input logic [ID_W-1:0] id);
      for (int i = 0; i < model_count; i++)
         if (model_event[i] == id)
            return i;
      return -1;
   endfunction

   task automatic drop_entry(input int pos);
      for (int i = pos; i + 1 < model_count; i++) begin
         model_expiry[i] = model_expiry[i + 1];
         model_event[i]  = model_event[i + 1];
      end
      model_count--;
   endtask

   // apply one request to the local table and queue the results it should cause
   task automatic predict_timer_request(input timer_request_type r);
      timer_result_type  batch[$];
      int                found;
      int                pos;
      logic [TIME_W-1:0] rem;
      logic [TIME_W-1:0] wait_ticks;
      found = find_event(r.event_id);
      case (r.mode)
         mtq_pkg::MODE_ADD: begin
            if (found >= 0) begin
               batch.push_back('{mtq_pkg::ST_DUPLICATE, r.event_id, 1'b1, 1'b0, 1'b0});
            end else if (model_count >= SLOT_COUNT) begin
               batch.push_back('{mtq_pkg::ST_FULL, r.event_id, 1'b0, 1'b0, 1'b0});
            end else begin
               // zero delay counts as one tick
               wait_ticks = (r.delay == 0) ? 1 : r.delay;
               pos = 0;
               rem = model_expiry[0] - model_now;
               while (pos < model_count && rem <= wait_ticks) begin
                  pos++;
                  rem = model_expiry[pos] - model_now;
               end
               for (int i = model_count; i > pos; i--) begin
                  model_expiry[i] = model_expiry[i - 1];
                  model_event[i]  = model_event[i - 1];
               end
               model_expiry[pos] = model_now + wait_ticks;
               model_event[pos]  = r.event_id;
               model_count++;
               batch.push_back('{mtq_pkg::ST_DONE, r.event_id, 1'b1, 1'b0, 1'b0});
            end
         end
         mtq_pkg::MODE_REMOVE: begin
            if (found < 0) begin
               batch.push_back('{mtq_pkg::ST_NOT_FOUND, r.event_id, 1'b0, 1'b0, 1'b0});
            end else begin
               drop_entry(found);
               batch.push_back('{mtq_pkg::ST_DONE, r.event_id, 1'b0, 1'b0, 1'b0});
            end
         end
         mtq_pkg::MODE_QUERY: begin
            batch.push_back('{mtq_pkg::ST_DONE, r.event_id, found >= 0, 1'b0, 1'b0});
         end
         default: begin
            // time holds still while events due now are still queued
            if (!(model_count > 0 && model_expiry[0] == model_now))
               model_now = model_now + 1;
            while (batch.size() < mtq_pkg::MAX_OUT && model_count > 0 &&
                   model_expiry[0] == model_now) begin
               batch.push_back('{mtq_pkg::ST_EXPIRED, model_event[0], 1'b0, 1'b0, 1'b0});
               drop_entry(0);
            end
            if (batch.size() == 0)
               batch.push_back('{mtq_pkg::ST_NONE_DUE, '0, 1'b0, 1'b0, 1'b0});
         end
      endcase
      foreach (batch[k]) begin
         batch[k].any_pending = (model_count > 0);
         batch[k].is_last     = (k == batch.size() - 1);
         due_results.push_back(batch[k]);
      end
   endtask

   // compare one result with the oldest expectation
   task automatic check_result();
      timer_result_type want;
      if (due_results.size() == 0) begin
         report_mismatch("unexpected result, status", rsp_status, 0);
      end else begin
         want = due_results.pop_front();
         if (rsp_status != want.status)
            report_mismatch("status", rsp_status, want.status);
         if (rsp_event_id_res != want.event_id)
            report_mismatch("event_id_res", rsp_event_id_res, want.event_id);
         if (rsp_pending != want.pending)
            report_mismatch("pending", rsp_pending, want.pending);
         if (rsp_any_pending != want.any_pending)
            report_mismatch("any_pending", rsp_any_pending, want.any_pending);
         if (rsp_last != want.is_last)
            report_mismatch("last", rsp_last, want.is_last);
      end
   endtask

   // driver: present the next request at the falling edge, idling at random except while issued_count is 70 to 119
   always @(negedge clock) begin
      if (!reset && taken_count == issued_count) begin
         if (queued_requests.size() > 0 &&
             ((issued_count >= 70 && issued_count < 120) || $urandom_range(99) >= 32)) begin
            {req_mode, req_event_id, req_delay} <= queued_requests.pop_front();
            start        <= 1'b1;
            issued_count <= issued_count + 1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: check results and predict each request as it is taken
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe)
            check_result();
         if (start && !busy) begin
            predict_timer_request('{req_mode, req_event_id, req_delay});
            taken_count <= taken_count + 1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int p;
      int id;
      int delay;

      // directed: fill the table, hit every error, expire a full table at once
      queue_request(mtq_pkg::MODE_ADD, 0, 0);
      for (int i = 1; i <= 14; i++)
         queue_request(mtq_pkg::MODE_ADD, (i * 37) & 8'hFE, 1);
      queue_request(mtq_pkg::MODE_ADD, 255, 65535);
      queue_request(mtq_pkg::MODE_ADD, 7, 3);
      queue_request(mtq_pkg::MODE_ADD, 0, 5);
      queue_request(mtq_pkg::MODE_QUERY, 255, 0);
      queue_request(mtq_pkg::MODE_QUERY, 100, 0);
      queue_request(mtq_pkg::MODE_REMOVE, 255, 0);
      queue_request(mtq_pkg::MODE_REMOVE, 255, 0);
      queue_request(mtq_pkg::MODE_ADD, 255, 1);
      queue_request(mtq_pkg::MODE_TICK, 0, 0);
      queue_request(mtq_pkg::MODE_TICK, 0, 0);

      // random: mostly a small id pool and short delays so events collide and expire
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         p  = $urandom_range(99);
         id = ($urandom_range(99) < 85) ? $urandom_range(19) : $urandom_range(255);
         case ($urandom_range(99) / 10)
            0, 1, 2, 3, 4, 5: delay = $urandom_range(4);
            6, 7, 8:          delay = $urandom_range(30, 5);
            default:          delay = ($urandom_range(9) < 7) ? $urandom_range(300, 31)
                                                             : $urandom_range(65535);
         endcase
         if (p < 36)
            queue_request(mtq_pkg::MODE_ADD, id, delay);
         else if (p < 52)
            queue_request(mtq_pkg::MODE_REMOVE, id, $urandom_range(65535));
         else if (p < 86)
            queue_request(mtq_pkg::MODE_TICK, $urandom_range(255), $urandom_range(65535));
         else
            queue_request(mtq_pkg::MODE_QUERY, id, $urandom_range(65535));
      end

      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // wait for every request to be taken and answered, then let the block settle
      while (taken_count < total_requests || due_results.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (due_results.size() > 0)
         report_mismatch("results never received", 0, due_results.size());

      if (error_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
